// ===== hdl/quad_signed_distance_defines.svh =====
// Assertion helpers shared by the checking code of the block.
`ifndef QUAD_SIGNED_DISTANCE_DEFINES_SVH
`define QUAD_SIGNED_DISTANCE_DEFINES_SVH

// Check a same-cycle implication on the block clock.
`define QSD_CHECK(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Check an implication in the next cycle on the block clock.
`define QSD_CHECK_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/qsd_pkg.sv =====
package qsd_pkg;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_VERTEX_X0 = 3'd0;
	localparam logic [2:0] REG_VERTEX_Y0 = 3'd1;
	localparam logic [2:0] REG_VERTEX_X1 = 3'd2;
	localparam logic [2:0] REG_VERTEX_Y1 = 3'd3;
	localparam logic [2:0] REG_VERTEX_X2 = 3'd4;
	localparam logic [2:0] REG_VERTEX_Y2 = 3'd5;
	localparam logic [2:0] REG_VERTEX_X3 = 3'd6;
	localparam logic [2:0] REG_VERTEX_Y3 = 3'd7;

	// Strict sign of one edge cross product
	typedef struct packed {
		logic pos;
		logic neg;
	} qsd_sign_t;

endpackage

// ===== hdl/qsd_edge.sv =====
module qsd_edge #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              in_valid,
	input  logic signed [COORD_WIDTH-1:0]     px,
	input  logic signed [COORD_WIDTH-1:0]     py,
	input  logic signed [COORD_WIDTH-1:0]     ax,
	input  logic signed [COORD_WIDTH-1:0]     ay,
	input  logic signed [COORD_WIDTH-1:0]     bx,
	input  logic signed [COORD_WIDTH-1:0]     by,
	output logic                              out_valid,
	output logic [4*COORD_WIDTH+3:0]          n,
	output logic [2*COORD_WIDTH+1:0]          den,
	output qsd_pkg::qsd_sign_t                sgn
);
	import qsd_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int D  = W + 1;
	localparam int CW = 2 * W + 2;
	localparam int SW = CW + 1;
	localparam int H  = W + 1;
	localparam int RW = 2 * CW;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	logic signed [D-1:0] ex_s1, ey_s1, wx_s1, wy_s1, qx_s1, qy_s1;

	logic signed [CW-1:0] exex_s2, eyey_s2, wxex_s2, wyey_s2, exwy_s2, eywx_s2;
	logic signed [CW-1:0] wxwx_s2, wywy_s2, qxqx_s2, qyqy_s2;

	logic [CW-1:0]        len_s3, dw_s3, dq_s3;
	logic signed [SW-1:0] dot_s3, cr_s3;

	logic          dot_le0, len_le_dot;
	logic [SW-1:0] cr_abs;

	logic          int_s4;
	logic [CW-1:0] nsel_s4, len_s4, crm_s4;
	qsd_sign_t     sgn_s4;

	logic [H-1:0]  hi, lo;
	logic          int_s5;
	logic [CW-1:0] nsel_s5, len_s5, hh_s5, hl_s5, ll_s5;
	qsd_sign_t     sgn_s5;

	logic [RW-1:0] n_s6;
	logic [CW-1:0] den_s6;
	qsd_sign_t     sgn_s6;

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	// Stage 1: edge vector and offsets from both ends
	always_ff @(posedge clk) begin
		if (adv) begin
			ex_s1 <= D'(bx) - D'(ax);
			ey_s1 <= D'(by) - D'(ay);
			wx_s1 <= D'(px) - D'(ax);
			wy_s1 <= D'(py) - D'(ay);
			qx_s1 <= D'(px) - D'(bx);
			qy_s1 <= D'(py) - D'(by);
		end
	end

	// Stage 2: products
	always_ff @(posedge clk) begin
		if (adv) begin
			exex_s2 <= CW'(ex_s1) * CW'(ex_s1);
			eyey_s2 <= CW'(ey_s1) * CW'(ey_s1);
			wxex_s2 <= CW'(wx_s1) * CW'(ex_s1);
			wyey_s2 <= CW'(wy_s1) * CW'(ey_s1);
			exwy_s2 <= CW'(ex_s1) * CW'(wy_s1);
			eywx_s2 <= CW'(ey_s1) * CW'(wx_s1);
			wxwx_s2 <= CW'(wx_s1) * CW'(wx_s1);
			wywy_s2 <= CW'(wy_s1) * CW'(wy_s1);
			qxqx_s2 <= CW'(qx_s1) * CW'(qx_s1);
			qyqy_s2 <= CW'(qy_s1) * CW'(qy_s1);
		end
	end

	// Stage 3: length, dot, cross and endpoint distances
	always_ff @(posedge clk) begin
		if (adv) begin
			len_s3 <= $unsigned(exex_s2) + $unsigned(eyey_s2);
			dot_s3 <= SW'(wxex_s2) + SW'(wyey_s2);
			cr_s3  <= SW'(exwy_s2) - SW'(eywx_s2);
			dw_s3  <= $unsigned(wxwx_s2) + $unsigned(wywy_s2);
			dq_s3  <= $unsigned(qxqx_s2) + $unsigned(qyqy_s2);
		end
	end

	// Stage 4: pick the projection region
	always_comb begin
		dot_le0    = dot_s3[SW-1] || (dot_s3 == '0);
		len_le_dot = len_s3 <= dot_s3[CW-1:0];
		cr_abs     = cr_s3[SW-1] ? $unsigned(-cr_s3) : $unsigned(cr_s3);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			int_s4     <= !dot_le0 && !len_le_dot;
			nsel_s4    <= dot_le0 ? dw_s3 : dq_s3;
			len_s4     <= len_s3;
			crm_s4     <= cr_abs[CW-1:0];
			sgn_s4.neg <= cr_s3[SW-1];
			sgn_s4.pos <= !cr_s3[SW-1] && (cr_s3 != '0);
		end
	end

	// Stage 5: square the cross magnitude in halves
	assign hi = crm_s4[CW-1:H];
	assign lo = crm_s4[H-1:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			hh_s5   <= CW'(hi) * CW'(hi);
			hl_s5   <= CW'(hi) * CW'(lo);
			ll_s5   <= CW'(lo) * CW'(lo);
			int_s5  <= int_s4;
			nsel_s5 <= nsel_s4;
			len_s5  <= len_s4;
			sgn_s5  <= sgn_s4;
		end
	end

	// Stage 6: radicand and divisor for the root
	always_ff @(posedge clk) begin
		if (adv) begin
			if (int_s5) begin
				n_s6   <= (RW'(hh_s5) << CW) + (RW'(hl_s5) << (H + 1)) + RW'(ll_s5);
				den_s6 <= len_s5;
			end else begin
				n_s6   <= RW'(nsel_s5);
				den_s6 <= CW'(1);
			end
			sgn_s6 <= sgn_s5;
		end
	end

	assign out_valid = v_s6;
	assign n         = n_s6;
	assign den       = den_s6;
	assign sgn       = sgn_s6;

endmodule

// ===== hdl/qsd_root.sv =====
module qsd_root #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  logic                     in_valid,
	input  logic [4*COORD_WIDTH+3:0] n,
	input  logic [2*COORD_WIDTH+1:0] den,
	input  qsd_pkg::qsd_sign_t       sgn,
	output logic                     out_valid,
	output logic [COORD_WIDTH-1:0]   root,
	output qsd_pkg::qsd_sign_t       root_sgn
);
	import qsd_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int CW = 2 * W + 2;
	localparam int RW = 2 * CW;
	localparam int XW = RW + 1;
	localparam int TW = W + CW;

	// Remainder n - m*m*den, running product m*den, partial root
	logic            v_s [0:W];
	logic [RW-1:0]   r_s [0:W];
	logic [TW-1:0]   t_s [0:W];
	logic [W-1:0]    m_s [0:W];
	logic [CW-1:0]   d_s [0:W];
	qsd_sign_t       g_s [0:W];

	assign v_s[0] = in_valid;
	assign r_s[0] = n;
	assign t_s[0] = '0;
	assign m_s[0] = '0;
	assign d_s[0] = den;
	assign g_s[0] = sgn;

	// One root bit per stage, most significant first
	for (genvar k = 0; k < W; k++) begin : g_step
		localparam int B = W - 1 - k;
		logic [XW-1:0] test;
		logic          take;

		always_comb begin
			test = (XW'(t_s[k]) << (B + 1)) + (XW'(d_s[k]) << (2 * B));
			take = test <= XW'(r_s[k]);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (adv) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				if (take) begin
					r_s[k+1] <= r_s[k] - test[RW-1:0];
					t_s[k+1] <= t_s[k] + (TW'(d_s[k]) << B);
					m_s[k+1] <= m_s[k] | (W'(1) << B);
				end else begin
					r_s[k+1] <= r_s[k];
					t_s[k+1] <= t_s[k];
					m_s[k+1] <= m_s[k];
				end
				d_s[k+1] <= d_s[k];
				g_s[k+1] <= g_s[k];
			end
		end
	end

	assign out_valid = v_s[W];
	assign root      = m_s[W];
	assign root_sgn  = g_s[W];

endmodule

// ===== hdl/quad_signed_distance.sv =====
// Signed distance from a query point to the quadrilateral spanned by four vertex
// registers (edges from vertex i to vertex i+1, wrapping), in signed Q format.
// One point is taken every cycle unless the output stalls. The square-root
// pipeline, one root bit per stage, runs for each edge side by side.
// A point whose edge crosses are all strictly positive or all strictly
// negative is inside and gets a negative distance. Magnitudes that do not fit
// are clamped to the largest positive value and flagged. Write the vertices
// only while no request is in flight. A stall on the output holds the whole pipe.
`include "quad_signed_distance_defines.svh"

module quad_signed_distance #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16,
	localparam int PDW = (COORD_WIDTH > 32) ? 64 : 32,
	localparam int ASH = (COORD_WIDTH > 32) ? 3 : 2,
	localparam int AW  = ASH + 3,
	localparam int IDW = ((2 * COORD_WIDTH + 7) / 8) * 8,
	localparam int ODW = ((COORD_WIDTH + 7) / 8) * 8
) (
	input  logic           clk,
	input  logic           arst_n,
	// APB configuration port
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [AW-1:0]  paddr,
	input  logic [PDW-1:0] pwdata,
	output logic [PDW-1:0] prdata,
	output logic           pready,
	// Query points
	input  logic           s_axis_tvalid,
	output logic           s_axis_tready,
	input  logic [IDW-1:0] s_axis_tdata,  // point_x, point_y
	// Results
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	output logic [ODW-1:0] m_axis_tdata,  // signed_distance
	output logic [1:0]     m_axis_tuser   // inside_flag, saturated_flag
);
	import qsd_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int CW = 2 * W + 2;
	localparam int RW = 2 * CW;
	localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;
	localparam logic [W-1:0] CAP = W'(1) << (W - 1);

	logic [W-1:0] vx_q [0:3];
	logic [W-1:0] vy_q [0:3];
	logic [2:0]   reg_idx;
	logic         wr_en;
	logic         adv;

	logic signed [W-1:0] px, py;

	logic            lane_valid [0:3];
	logic [RW-1:0]   lane_n     [0:3];
	logic [CW-1:0]   lane_den   [0:3];
	qsd_sign_t       lane_sgn   [0:3];
	logic            root_valid [0:3];
	logic [W-1:0]    root_m     [0:3];
	qsd_sign_t       root_sgn   [0:3];
	logic [W-1:0]    clip       [0:3];

	logic         v_f1, inside_f1;
	logic [W-1:0] min01_f1, min23_f1;
	logic [W-1:0] best, mag;
	logic         sat;

	logic         out_valid_q, inside_q, sat_q;
	logic [W-1:0] dist_q;

	// Configuration writes
	assign pready  = 1'b1;
	assign reg_idx = paddr[AW-1:ASH];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vx_q[0] <= '0;
			vy_q[0] <= '0;
			vx_q[1] <= ONE;
			vy_q[1] <= '0;
			vx_q[2] <= ONE;
			vy_q[2] <= ONE;
			vx_q[3] <= '0;
			vy_q[3] <= ONE;
		end else if (wr_en) begin
			case (reg_idx)
				REG_VERTEX_X0: vx_q[0] <= pwdata[W-1:0];
				REG_VERTEX_Y0: vy_q[0] <= pwdata[W-1:0];
				REG_VERTEX_X1: vx_q[1] <= pwdata[W-1:0];
				REG_VERTEX_Y1: vy_q[1] <= pwdata[W-1:0];
				REG_VERTEX_X2: vx_q[2] <= pwdata[W-1:0];
				REG_VERTEX_Y2: vy_q[2] <= pwdata[W-1:0];
				REG_VERTEX_X3: vx_q[3] <= pwdata[W-1:0];
				REG_VERTEX_Y3: vy_q[3] <= pwdata[W-1:0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (reg_idx)
			REG_VERTEX_X0: prdata = PDW'(vx_q[0]);
			REG_VERTEX_Y0: prdata = PDW'(vy_q[0]);
			REG_VERTEX_X1: prdata = PDW'(vx_q[1]);
			REG_VERTEX_Y1: prdata = PDW'(vy_q[1]);
			REG_VERTEX_X2: prdata = PDW'(vx_q[2]);
			REG_VERTEX_Y2: prdata = PDW'(vy_q[2]);
			REG_VERTEX_X3: prdata = PDW'(vx_q[3]);
			REG_VERTEX_Y3: prdata = PDW'(vy_q[3]);
			default:       prdata = '0;
		endcase
	end

	// Advance the whole pipe unless the output holds an untaken result
	assign adv           = !out_valid_q || m_axis_tready;
	assign s_axis_tready = adv;

	assign px = s_axis_tdata[W-1:0];
	assign py = s_axis_tdata[2*W-1:W];

	// One lane per edge
	for (genvar i = 0; i < 4; i++) begin : g_lane
		qsd_edge #(
			.COORD_WIDTH(COORD_WIDTH)
		) u_edge (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_valid (s_axis_tvalid),
			.px       (px),
			.py       (py),
			.ax       (vx_q[i]),
			.ay       (vy_q[i]),
			.bx       (vx_q[(i + 1) % 4]),
			.by       (vy_q[(i + 1) % 4]),
			.out_valid(lane_valid[i]),
			.n        (lane_n[i]),
			.den      (lane_den[i]),
			.sgn      (lane_sgn[i])
		);

		qsd_root #(
			.COORD_WIDTH(COORD_WIDTH)
		) u_root (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_valid (lane_valid[i]),
			.n        (lane_n[i]),
			.den      (lane_den[i]),
			.sgn      (lane_sgn[i]),
			.out_valid(root_valid[i]),
			.root     (root_m[i]),
			.root_sgn (root_sgn[i])
		);

		assign clip[i] = (root_m[i] >= CAP) ? CAP : root_m[i];
	end

	// First reduction stage: pairwise minimum and inside test
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_f1 <= 1'b0;
		end else if (adv) begin
			v_f1 <= root_valid[0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			min01_f1  <= (clip[0] < clip[1]) ? clip[0] : clip[1];
			min23_f1  <= (clip[2] < clip[3]) ? clip[2] : clip[3];
			inside_f1 <= (root_sgn[0].pos && root_sgn[1].pos && root_sgn[2].pos &&
				root_sgn[3].pos) || (root_sgn[0].neg && root_sgn[1].neg &&
				root_sgn[2].neg && root_sgn[3].neg);
		end
	end

	// Final minimum, clamp and sign
	always_comb begin
		best = (min01_f1 < min23_f1) ? min01_f1 : min23_f1;
		sat  = best >= CAP;
		mag  = sat ? (CAP - W'(1)) : best;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_f1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dist_q   <= inside_f1 ? (W'(0) - mag) : mag;
			inside_q <= inside_f1;
			sat_q    <= sat;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = ODW'(dist_q);
	assign m_axis_tuser  = {sat_q, inside_q};

	// Checks
	`QSD_CHECK(a_lane_sync, root_valid[0], root_valid[1] && root_valid[2] && root_valid[3], "edge lanes out of step")
	`QSD_CHECK_NEXT(a_final_to_out, v_f1 && adv, out_valid_q, "reduced result not registered")
	`QSD_CHECK(a_inside_nonpos, out_valid_q && inside_q, $signed(dist_q) <= 0, "inside point with positive distance")
	`QSD_CHECK(a_sat_clamp, out_valid_q && sat_q && !inside_q, dist_q == (CAP - W'(1)), "saturated distance not clamped")

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import qsd_pkg::*;

	typedef logic signed [199:0] wide_t;

	typedef struct packed {
		logic [31:0] distance;
		logic        in_quad;
		logic        sat;
	} dist_result_t;

	typedef struct packed {
		logic [31:0]  x;
		logic [31:0]  y;
		logic         typed;
		dist_result_t res;
	} point_row_t;

	localparam logic [31:0] ONE  = 32'h0001_0000;
	localparam logic [31:0] HALF = 32'h0000_8000;
	localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
	localparam logic [31:0] MINV = 32'h8000_0000;
	localparam int CYCLE_LIMIT = 600000;
	localparam int PIPE_DRAIN  = 60;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata;  // point_x, point_y
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;  // signed_distance
	logic [1:0]  m_axis_tuser;  // inside_flag, saturated_flag

	// vertex copy kept by the bench, updated on each register write
	logic signed [31:0] vert_x [4];
	logic signed [31:0] vert_y [4];

	dist_result_t distance_queue[$];
	logic         row_typed;
	dist_result_t row_result;
	int           err_count;
	int           cycle_count;
	logic         tx_idle_en;
	logic         rx_idle_en;
	int           rx_hold;

	quad_signed_distance DUT (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Largest m with m*m*den <= n, capped at 2^31
	function automatic logic [31:0] root_floor(wide_t n, wide_t den);
		wide_t       wc;
		logic [31:0] m;
		logic [31:0] cand;
		m = '0;
		wc = 1;
		wc = wc <<< 31;
		if (wc * wc * den <= n)
			return MINV;
		for (int b = 30; b >= 0; b--) begin
			cand = m | (32'd1 << b);
			wc = {168'd0, cand};
			if (wc * wc * den <= n)
				m = cand;
		end
		return m;
	endfunction

	// Signed distance of one query point to the current quadrilateral
	function automatic dist_result_t quad_distance(logic signed [31:0] px,
			logic signed [31:0] py);
		dist_result_t r;
		wide_t ax, ay, bx, by, ex, ey, wx, wy, qx, qy, len, dot, cr;
		wide_t wpx, wpy;
		logic [31:0] best, m;
		int pos, neg;
		best = MINV;
		pos = 0;
		neg = 0;
		wpx = px;
		wpy = py;
		for (int i = 0; i < 4; i++) begin
			ax = vert_x[i];
			ay = vert_y[i];
			bx = vert_x[(i + 1) % 4];
			by = vert_y[(i + 1) % 4];
			ex = bx - ax;
			ey = by - ay;
			wx = wpx - ax;
			wy = wpy - ay;
			len = ex * ex + ey * ey;
			dot = wx * ex + wy * ey;
			cr = ex * wy - ey * wx;
			if (dot <= 0) begin
				m = root_floor(wx * wx + wy * wy, 1);
			end else if (len <= dot) begin
				qx = wpx - bx;
				qy = wpy - by;
				m = root_floor(qx * qx + qy * qy, 1);
			end else begin
				m = root_floor(cr * cr, len);
			end
			if (m < best)
				best = m;
			if (cr > 0)
				pos++;
			else if (cr < 0)
				neg++;
		end
		r.in_quad = (pos == 4) || (neg == 4);
		r.sat = (best >= MINV);
		m = r.sat ? MAXV : best;
		r.distance = r.in_quad ? (32'd0 - m) : m;
		return r;
	endfunction

	// Track register writes in the bench copy of the vertices
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vert_x[0] <= 0;   vert_y[0] <= 0;
			vert_x[1] <= ONE; vert_y[1] <= 0;
			vert_x[2] <= ONE; vert_y[2] <= ONE;
			vert_x[3] <= 0;   vert_y[3] <= ONE;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2])
				vert_y[paddr[4:3]] <= pwdata;
			else
				vert_x[paddr[4:3]] <= pwdata;
		end
	end

	// Predict on each accepted request
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			if (row_typed)
				distance_queue.push_back(row_result);
			else
				distance_queue.push_back(quad_distance(s_axis_tdata[31:0],
					s_axis_tdata[63:32]));
		end
	end

	// Stall the output in random bursts and check each result
	always @(posedge clk or negedge arst_n) begin
		dist_result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_hold <= 0;
		end else begin
			if (rx_hold > 0) begin
				rx_hold <= rx_hold - 1;
				m_axis_tready <= 1'b0;
			end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
				rx_hold <= $urandom_range(1, 19) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (distance_queue.size() == 0) begin
					$display("%0t: result with none expected: dist %h user %b",
						$time, m_axis_tdata, m_axis_tuser);
					err_count++;
				end else begin
					want = distance_queue.pop_front();
					if (m_axis_tdata !== want.distance) begin
						$display("%0t: distance expected %h actual %h",
							$time, want.distance, m_axis_tdata);
						err_count++;
					end
					if (m_axis_tuser[0] !== want.in_quad) begin
						$display("%0t: inside expected %b actual %b",
							$time, want.in_quad, m_axis_tuser[0]);
						err_count++;
					end
					if (m_axis_tuser[1] !== want.sat) begin
						$display("%0t: saturated expected %b actual %b",
							$time, want.sat, m_axis_tuser[1]);
						err_count++;
					end
				end
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Hold off until every expected result has come and the pipe is empty
	task automatic drain_pipe();
		while (distance_queue.size() != 0)
			@(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
	endtask

	task automatic set_quad(logic [31:0] x0, y0, x1, y1, x2, y2, x3, y3);
		// drop the last request before waiting for the pipe to empty
		s_axis_tvalid <= 1'b0;
		drain_pipe();
		write_reg(REG_VERTEX_X0, x0);
		write_reg(REG_VERTEX_Y0, y0);
		write_reg(REG_VERTEX_X1, x1);
		write_reg(REG_VERTEX_Y1, y1);
		write_reg(REG_VERTEX_X2, x2);
		write_reg(REG_VERTEX_Y2, y2);
		write_reg(REG_VERTEX_X3, x3);
		write_reg(REG_VERTEX_Y3, y3);
	endtask

	// Offer one request, at times with a random gap before it, and wait for acceptance
	task automatic send_point(logic [31:0] x, logic [31:0] y, logic typed,
			dist_result_t res);
		logic ok;
		if (tx_idle_en && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {y, x};
		row_typed <= typed;
		row_result <= res;
		do begin
			@(negedge clk);
			ok = s_axis_tready;
			@(posedge clk);
		end while (!ok);
	endtask

	function automatic logic [31:0] near(logic [31:0] c, int spread);
		return c + $signed($urandom_range(0, 2 * spread)) - spread;
	endfunction

	function automatic logic [31:0] rand_coord(int spread);
		return $signed($urandom_range(0, 2 * spread)) - spread;
	endfunction

	task automatic random_points(int count);
		logic [31:0] x, y;
		int k;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(0, 3))
				0: begin
					x = $urandom;
					y = $urandom;
				end
				1: begin
					k = $urandom_range(0, 3);
					x = near(vert_x[k], 1 << $urandom_range(0, 20));
					y = near(vert_y[k], 1 << $urandom_range(0, 20));
				end
				default: begin
					// blend of two vertices, lands inside or on the hull often
					k = $urandom_range(0, 3);
					x = (vert_x[k] >>> 1) + (vert_x[(k + 2) % 4] >>> 1);
					y = (vert_y[k] >>> 1) + (vert_y[(k + 2) % 4] >>> 1);
					x = near(x, 1 << $urandom_range(0, 18));
					y = near(y, 1 << $urandom_range(0, 18));
				end
			endcase
			send_point(x, y, 1'b0, '0);
		end
	endtask

	task automatic random_quad(int spread);
		set_quad(rand_coord(spread), rand_coord(spread), rand_coord(spread),
			rand_coord(spread), rand_coord(spread), rand_coord(spread),
			rand_coord(spread), rand_coord(spread));
	endtask

	point_row_t directed_rows[$];

	initial begin
		err_count = 0;
		cycle_count = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		row_typed = 1'b0;
		row_result = '0;
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unit square after reset: center, vertex, outside, extremes, edge
		directed_rows = '{
			'{HALF, HALF, 1'b1, '{32'hFFFF_8000, 1'b1, 1'b0}},
			'{32'd0, 32'd0, 1'b1, '{32'd0, 1'b0, 1'b0}},
			'{32'h0002_0000, HALF, 1'b1, '{ONE, 1'b0, 1'b0}},
			'{MINV, MINV, 1'b1, '{MAXV, 1'b0, 1'b1}},
			'{MAXV, MAXV, 1'b1, '{MAXV, 1'b0, 1'b1}},
			'{MINV, MAXV, 1'b1, '{MAXV, 1'b0, 1'b1}},
			'{HALF, 32'd0, 1'b1, '{32'd0, 1'b0, 1'b0}},
			'{HALF, 32'hFFFF_0000, 1'b1, '{ONE, 1'b0, 1'b0}},
			'{32'h0000_4000, HALF, 1'b0, '0},
			'{32'd1, 32'd1, 1'b0, '0},
			'{32'hFFFF_FFFF, 32'h0001_0001, 1'b0, '0},
			'{MAXV, 32'd0, 1'b0, '0}
		};
		foreach (directed_rows[i])
			send_point(directed_rows[i].x, directed_rows[i].y,
				directed_rows[i].typed, directed_rows[i].res);
		s_axis_tvalid <= 1'b0;

		// degenerate edges: all four vertices at one point
		set_quad(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE);
		send_point(ONE, ONE, 1'b1, '{32'd0, 1'b0, 1'b0});
		send_point(32'h0002_0000, ONE, 1'b1, '{ONE, 1'b0, 1'b0});
		send_point(32'd0, 32'd0, 1'b0, '0);
		// extreme corners of the coordinate range, clockwise
		set_quad(MINV, MINV, MINV, MAXV, MAXV, MAXV, MAXV, MINV);
		send_point(32'd0, 32'd0, 1'b0, '0);
		send_point(MINV, MINV, 1'b0, '0);
		send_point(32'h1234_5678, 32'h8765_4321, 1'b0, '0);
		// self-intersecting bow tie
		set_quad(32'd0, 32'd0, ONE, ONE, ONE, 32'd0, 32'd0, ONE);
		send_point(HALF, 32'h0000_4000, 1'b0, '0);
		send_point(HALF, HALF, 1'b0, '0);
		s_axis_tvalid <= 1'b0;

		// random shapes at several scales, with idling
		for (int ph = 0; ph < 5; ph++) begin
			random_quad(ph == 4 ? 32'h7FFF_FFFF : (1 << (16 + 3 * ph)));
			random_points(240);
			s_axis_tvalid <= 1'b0;
			if (ph == 2) begin
				// let the pipe empty completely before the next request
				drain_pipe();
				random_points(10);
				s_axis_tvalid <= 1'b0;
			end
		end

		// last stretch at full rate
		set_quad(MINV, 32'd0, 32'd0, MAXV, MAXV, 32'd0, 32'd0, MINV);
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		random_points(220);
		s_axis_tvalid <= 1'b0;

		while (distance_queue.size() != 0)
			@(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
